### rtl/sliding_window_max_rise_unit_assert.svh
// Assertion macros of the sliding window max rise unit.
`ifndef SLIDING_WINDOW_MAX_RISE_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MAX_RISE_UNIT_ASSERT_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define SWMR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define SWMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/swmr_pkg.sv
// Package with types and constants of the sliding window max rise unit.
package swmr_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int WL_W           = 7;
  localparam int WINDOW_MAX_DEF = 64;
  localparam logic [WL_W-1:0] WL_RESET = WL_W'(5);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       new_sequence;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_min;
    logic [SAMPLE_W-1:0]        current_rise;
    logic [SAMPLE_W-1:0]        max_rise;
  } result_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic pop_back;
    logic pop_front;
    logic push;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic nonempty;
    logic back_gt;
    logic front_expired;
  } dp_status_t;

endpackage

### rtl/sliding_window_max_rise_unit.sv
// Top level of the sliding window max rise unit.
//
//   channel | direction | handshake                 | payload
//   item    | in        | item_valid / item_stall   | item_t (sample, new_sequence)
//   result  | out       | result_valid / result_stall | result_t (min, rise, max rise)
//   cfg     | in        | cfg_valid / cfg_ready     | window_length, 7 bits
//
// A sample is loaded, drops deque entries from the back and the front, then is appended;
// each drop is one step through the registered read ports of the deque memory.
// Reset empties the deque (by count), clears position and max rise, window is 5.
// A finished result waits in the output register; while it stays stalled the
// next sample is held before its append.
module sliding_window_max_rise_unit
  import swmr_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  item_t           item,
  output logic            result_valid,
  input  logic            result_stall,
  output result_t         result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [WL_W-1:0] cfg_data
);

`include "sliding_window_max_rise_unit_assert.svh"

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [3:0] cmd_vec;
  logic       any_pop;

  // The register write is always taken
  assign cfg_ready = 1'b1;

  swmr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  swmr_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // Gather the datapath commands for the checks below
  assign cmd_vec = {cmd.load, cmd.pop_back, cmd.pop_front, cmd.push};
  assign any_pop = cmd.pop_back || cmd.pop_front;

  `SWMR_ASSERT_NEXT(a_busy_after_load, clk, rst, cmd.load, item_stall, "load left input open")
  `SWMR_ASSERT_NEXT(a_push_gives_result, clk, rst, cmd.push, result_valid, "append gave no result")
  `SWMR_ASSERT_SAME(a_pop_nonempty, clk, rst, any_pop, status.nonempty, "pop from empty deque")
  `SWMR_ASSERT_SAME(a_one_command, clk, rst, 1'b1, $onehot0(cmd_vec), "several commands at once")

endmodule

### rtl/swmr_ctrl.sv
// Controller state machine of the sliding window max rise unit.
module swmr_ctrl
  import swmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  output logic       result_valid,
  input  logic       result_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CHECK = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register can take a new result when empty or being drained
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE);

  // Decide the next step: trim the back, then the front, then append
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.back_gt) begin
          cmd.pop_back = 1'b1;
        end else if (status.front_expired) begin
          cmd.pop_front = 1'b1;
        end else if (out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result until the far side takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

### rtl/swmr_dp.sv
// Datapath of the sliding window max rise unit: deque memory, pointers, result.
module swmr_dp
  import swmr_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [WL_W-1:0] cfg_data,
  input  item_t           item,
  input  dp_cmd_t         cmd,
  output dp_status_t      status,
  output result_t         result
);

  localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int PMOD = 2 * WINDOW_MAX;
  localparam int PW   = $clog2(PMOD);
  localparam int EW   = (PW > WL_W) ? PW : WL_W;

  localparam logic [AW-1:0] LAST_IDX  = AW'(WINDOW_MAX - 1);
  localparam logic [PW-1:0] LAST_POS  = PW'(PMOD - 1);
  localparam logic [PW:0]   POS_MOD_V = (PW + 1)'(PMOD);
  localparam logic [EW-1:0] WIN_MAX_V = EW'(WINDOW_MAX);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? LAST_IDX : p - AW'(1);
  endfunction

  // Deque storage, circular between head and tail
  logic signed [SAMPLE_W-1:0] val_mem [WINDOW_MAX];
  logic [PW-1:0]              pos_mem [WINDOW_MAX];

  logic [WL_W-1:0]            window_length;
  logic [AW-1:0]              head, head_next;
  logic [AW-1:0]              tail, tail_next;
  logic [CW-1:0]              count, count_next;
  logic [PW-1:0]              pos, pos_next;
  logic [SAMPLE_W-1:0]        best, best_next;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] back_val;
  logic signed [SAMPLE_W-1:0] front_val;
  logic [PW-1:0]              front_pos;
  logic [AW-1:0]              back_addr;
  logic [EW-1:0]              win_eff;
  logic [PW:0]                age;
  logic signed [SAMPLE_W-1:0] min_sel;
  logic [SAMPLE_W-1:0]        rise;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_RESET;
    end else if (cfg_write) begin
      window_length <= cfg_data;
    end
  end

  // Clamp the window to the range one to the deque depth
  always_comb begin
    win_eff = EW'(window_length);
    if (window_length == '0) begin
      win_eff = EW'(1);
    end else if (win_eff > WIN_MAX_V) begin
      win_eff = WIN_MAX_V;
    end
  end

  // Age of the front entry, positions counted modulo twice the depth
  always_comb begin
    if (pos >= front_pos) begin
      age = {1'b0, pos} - {1'b0, front_pos};
    end else begin
      age = {1'b0, pos} + POS_MOD_V - {1'b0, front_pos};
    end
  end

  assign status.nonempty      = (count != '0);
  assign status.back_gt       = status.nonempty && (sample_q < back_val);
  assign status.front_expired = status.nonempty && (EW'(age[PW-1:0]) >= win_eff);

  // Result of the append: front holds the minimum, or the new sample alone
  assign min_sel   = status.nonempty ? front_val : sample_q;
  assign rise      = SAMPLE_W'(sample_q - min_sel);
  assign best_next = (rise > best) ? rise : best;

  // Next pointer values
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    pos_next   = pos;
    if (cmd.load && item.new_sequence) begin
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
      pos_next   = '0;
    end else if (cmd.pop_back) begin
      tail_next  = ptr_dec(tail);
      count_next = count - CW'(1);
    end else if (cmd.pop_front) begin
      head_next  = ptr_inc(head);
      count_next = count - CW'(1);
    end else if (cmd.push) begin
      tail_next  = ptr_inc(tail);
      count_next = count + CW'(1);
      pos_next   = (pos == LAST_POS) ? '0 : pos + PW'(1);
    end
  end

  assign back_addr = ptr_dec(tail_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      pos   <= '0;
      best  <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      pos   <= pos_next;
      if (cmd.load && item.new_sequence) begin
        best <= '0;
      end else if (cmd.push) begin
        best <= best_next;
      end
    end
  end

  // Capture the incoming sample
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= item.sample;
    end
  end

  // Append at the tail
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      val_mem[tail] <= sample_q;
      pos_mem[tail] <= pos;
    end
  end

  // Read back and front entries at the pointers of the coming cycle
  always_ff @(posedge clk) begin
    back_val  <= val_mem[back_addr];
    front_val <= val_mem[head_next];
    front_pos <= pos_mem[head_next];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      result.window_min   <= min_sel;
      result.current_rise <= rise;
      result.max_rise     <= best_next;
    end
  end

endmodule
